// ----- src/teq_pkg.sv -----
package teq_pkg;

	localparam int COEF_W    = 18;
	localparam int GAIN_W    = 20;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_POLES = 4;
	localparam int POLE_IDX_W = 2;
	localparam int DLY_DEPTH = 3;
	localparam int PC_W      = 5;
	localparam int MUL_B_W   = GAIN_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd4;

	localparam logic [COEF_W-1:0] LOW_COEF_RST  = 18'd7545;
	localparam logic [COEF_W-1:0] HIGH_COEF_RST = 18'd42131;
	localparam logic [GAIN_W-1:0] GAIN_RST      = 20'd65536;

	typedef logic [PC_W-1:0] pc_t;
	typedef logic [POLE_IDX_W-1:0] pidx_t;

	localparam pc_t PC_START = 5'd0;

	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_IN,
		SEQ_OUT,
		SEQ_JUMP
	} seq_op_t;

	typedef enum logic [1:0] {
		CAS_NOP,
		CAS_DIFF,
		CAS_UPD
	} cas_op_t;

	typedef enum logic [1:0] {
		MSRC_NONE,
		MSRC_DL,
		MSRC_DH,
		MSRC_CL
	} mul_src_t;

	typedef enum logic [2:0] {
		MCOEF_LOW,
		MCOEF_HIGH,
		MGAIN_LOW,
		MGAIN_MID,
		MGAIN_HIGH
	} mul_coef_t;

	typedef enum logic [1:0] {
		ACC_NOP,
		ACC_LOAD,
		ACC_ADD,
		ACC_OUT
	} acc_op_t;

	typedef struct packed {
		seq_op_t   seq;
		pc_t       tgt;
		cas_op_t   l_op;
		pidx_t     l_idx;
		cas_op_t   h_op;
		pidx_t     h_idx;
		mul_src_t  mul_src;
		mul_coef_t mul_coef;
		logic      band;
		acc_op_t   acc;
	} ctl_t;

	typedef struct packed {
		logic [COEF_W-1:0] low_coef;
		logic [COEF_W-1:0] high_coef;
		logic [GAIN_W-1:0] low_gain;
		logic [GAIN_W-1:0] mid_gain;
		logic [GAIN_W-1:0] high_gain;
	} cfg_t;

	function automatic ctl_t cw(input seq_op_t seq, input pc_t tgt,
			input cas_op_t l_op, input pidx_t l_idx,
			input cas_op_t h_op, input pidx_t h_idx,
			input mul_src_t mul_src, input mul_coef_t mul_coef,
			input logic band, input acc_op_t acc);
		ctl_t c;
		c.seq      = seq;
		c.tgt      = tgt;
		c.l_op     = l_op;
		c.l_idx    = l_idx;
		c.h_op     = h_op;
		c.h_idx    = h_idx;
		c.mul_src  = mul_src;
		c.mul_coef = mul_coef;
		c.band     = band;
		c.acc      = acc;
		return c;
	endfunction

	// Cascades interleaved on one multiplier: diff, multiply, update per stage.
	function automatic ctl_t prog_rom(input pc_t a);
		ctl_t c;
		case (a)
			5'd0: c = cw(SEQ_IN, PC_START, CAS_DIFF, 2'd0, CAS_DIFF, 2'd0,
				MSRC_NONE, MCOEF_LOW, 1'b0, ACC_NOP);
			5'd1: c = cw(SEQ_NEXT, PC_START, CAS_NOP, 2'd0, CAS_NOP, 2'd0,
				MSRC_DL, MCOEF_LOW, 1'b0, ACC_NOP);
			5'd2: c = cw(SEQ_NEXT, PC_START, CAS_UPD, 2'd0, CAS_NOP, 2'd0,
				MSRC_DH, MCOEF_HIGH, 1'b0, ACC_NOP);
			5'd3: c = cw(SEQ_NEXT, PC_START, CAS_DIFF, 2'd1, CAS_UPD, 2'd0,
				MSRC_NONE, MCOEF_LOW, 1'b0, ACC_NOP);
			5'd4: c = cw(SEQ_NEXT, PC_START, CAS_NOP, 2'd1, CAS_DIFF, 2'd1,
				MSRC_DL, MCOEF_LOW, 1'b0, ACC_NOP);
			5'd5: c = cw(SEQ_NEXT, PC_START, CAS_UPD, 2'd1, CAS_NOP, 2'd1,
				MSRC_DH, MCOEF_HIGH, 1'b0, ACC_NOP);
			5'd6: c = cw(SEQ_NEXT, PC_START, CAS_DIFF, 2'd2, CAS_UPD, 2'd1,
				MSRC_NONE, MCOEF_LOW, 1'b0, ACC_NOP);
			5'd7: c = cw(SEQ_NEXT, PC_START, CAS_NOP, 2'd2, CAS_DIFF, 2'd2,
				MSRC_DL, MCOEF_LOW, 1'b0, ACC_NOP);
			5'd8: c = cw(SEQ_NEXT, PC_START, CAS_UPD, 2'd2, CAS_NOP, 2'd2,
				MSRC_DH, MCOEF_HIGH, 1'b0, ACC_NOP);
			5'd9: c = cw(SEQ_NEXT, PC_START, CAS_DIFF, 2'd3, CAS_UPD, 2'd2,
				MSRC_NONE, MCOEF_LOW, 1'b0, ACC_NOP);
			5'd10: c = cw(SEQ_NEXT, PC_START, CAS_NOP, 2'd3, CAS_DIFF, 2'd3,
				MSRC_DL, MCOEF_LOW, 1'b0, ACC_NOP);
			5'd11: c = cw(SEQ_NEXT, PC_START, CAS_UPD, 2'd3, CAS_NOP, 2'd3,
				MSRC_DH, MCOEF_HIGH, 1'b0, ACC_NOP);
			5'd12: c = cw(SEQ_NEXT, PC_START, CAS_NOP, 2'd0, CAS_UPD, 2'd3,
				MSRC_CL, MGAIN_LOW, 1'b0, ACC_NOP);
			5'd13: c = cw(SEQ_NEXT, PC_START, CAS_NOP, 2'd0, CAS_NOP, 2'd0,
				MSRC_NONE, MCOEF_LOW, 1'b1, ACC_LOAD);
			5'd14: c = cw(SEQ_NEXT, PC_START, CAS_NOP, 2'd0, CAS_NOP, 2'd0,
				MSRC_DL, MGAIN_MID, 1'b0, ACC_NOP);
			5'd15: c = cw(SEQ_NEXT, PC_START, CAS_NOP, 2'd0, CAS_NOP, 2'd0,
				MSRC_DH, MGAIN_HIGH, 1'b0, ACC_ADD);
			5'd16: c = cw(SEQ_OUT, PC_START, CAS_NOP, 2'd0, CAS_NOP, 2'd0,
				MSRC_NONE, MCOEF_LOW, 1'b0, ACC_OUT);
			default: c = cw(SEQ_JUMP, PC_START, CAS_NOP, 2'd0, CAS_NOP, 2'd0,
				MSRC_NONE, MCOEF_LOW, 1'b0, ACC_NOP);
		endcase
		return c;
	endfunction

endpackage

// ----- src/three_band_equalizer_unit.sv -----
// Three-band equalizer, signed fixed point, one sample in, one sample out.
// Input channel: in_valid/in_ready with sample_in; a beat is taken when both
// are high. Output channel: out_valid/out_ready with sample_out, held in an
// output register until taken.
// A 17-step microprogram drives one shared multiplier through the eight
// cascade products and the three gain products, so a new sample is taken only
// once the program has run through all steps for the last one. The result
// shows on out_valid from the output register, written at the last step.
// A result may wait in the output register while the next sample is already
// taken and processed; if the receiver stalls, the program holds at its last
// step until the output register frees, and in_ready stays low meanwhile.
// Configuration: cfg_we, cfg_idx, cfg_data write one coefficient or gain per
// cycle, to be done only while the block is idle.
// Reset (arst_n low) clears filter state and the input delay, restores the
// default coefficients and gains, and empties the output register.
module three_band_equalizer_unit #(
	parameter int FRAC_BITS    = 16,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	input  logic                                cfg_we,
	input  logic [teq_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [teq_pkg::CFG_W-1:0]           cfg_data
);

	teq_pkg::cfg_t cfg_q;
	teq_pkg::ctl_t ctl;
	logic          out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_coef  <= teq_pkg::LOW_COEF_RST;
			cfg_q.high_coef <= teq_pkg::HIGH_COEF_RST;
			cfg_q.low_gain  <= teq_pkg::GAIN_RST;
			cfg_q.mid_gain  <= teq_pkg::GAIN_RST;
			cfg_q.high_gain <= teq_pkg::GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				teq_pkg::REG_LOW_COEF:  cfg_q.low_coef  <= cfg_data[teq_pkg::COEF_W-1:0];
				teq_pkg::REG_HIGH_COEF: cfg_q.high_coef <= cfg_data[teq_pkg::COEF_W-1:0];
				teq_pkg::REG_LOW_GAIN:  cfg_q.low_gain  <= cfg_data[teq_pkg::GAIN_W-1:0];
				teq_pkg::REG_MID_GAIN:  cfg_q.mid_gain  <= cfg_data[teq_pkg::GAIN_W-1:0];
				teq_pkg::REG_HIGH_GAIN: cfg_q.high_gain <= cfg_data[teq_pkg::GAIN_W-1:0];
				default:                cfg_q <= cfg_q;
			endcase
		end
	end

	teq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.ctl      (ctl),
		.in_ready (in_ready)
	);

	teq_dp #(
		.FRAC_BITS    (FRAC_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.sample_in  (sample_in),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.sample_out (sample_out),
		.out_free   (out_free)
	);

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sequencer did not leave idle after input beat");

	a_hold_final: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.acc == teq_pkg::ACC_OUT) && !out_free |=> (ctl.acc == teq_pkg::ACC_OUT))
		else $error("final step left while output register busy");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl.acc == teq_pkg::ACC_OUT))
		else $error("output valid raised outside final step");

endmodule

// ----- src/teq_seq.sv -----
module teq_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_free,
	output teq_pkg::ctl_t   ctl,
	output logic            in_ready
);

	teq_pkg::pc_t pc_q;
	teq_pkg::pc_t pc_d;

	always_comb begin
		ctl      = teq_pkg::prog_rom(pc_q);
		in_ready = (ctl.seq == teq_pkg::SEQ_IN);
	end

	always_comb begin
		case (ctl.seq)
			teq_pkg::SEQ_NEXT: pc_d = teq_pkg::pc_t'(pc_q + 1'b1);
			teq_pkg::SEQ_IN:   pc_d = in_valid ? teq_pkg::pc_t'(pc_q + 1'b1) : pc_q;
			teq_pkg::SEQ_OUT:  pc_d = out_free ? ctl.tgt : pc_q;
			teq_pkg::SEQ_JUMP: pc_d = ctl.tgt;
			default:           pc_d = teq_pkg::PC_START;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= teq_pkg::PC_START;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ----- src/teq_dp.sv -----
module teq_dp #(
	parameter int FRAC_BITS    = 16,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  teq_pkg::ctl_t                  ctl,
	input  teq_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	output logic                           out_free
);

	localparam int W  = SAMPLE_WIDTH;
	localparam int PW = SAMPLE_WIDTH + teq_pkg::MUL_B_W;
	localparam int AW = PW + 1;
	localparam int BW = teq_pkg::MUL_B_W;

	logic signed [W-1:0]  x_q, cur_l_q, cur_h_q, d_l_q, d_h_q, out_q;
	logic signed [W-1:0]  pole_l_q [teq_pkg::NUM_POLES];
	logic signed [W-1:0]  pole_h_q [teq_pkg::NUM_POLES];
	logic signed [W-1:0]  dly_q [teq_pkg::DLY_DEPTH];
	logic signed [PW-1:0] prod_q, mul_full;
	logic signed [AW-1:0] acc_q, sum, prod_x;
	logic signed [W-1:0]  mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [W-1:0]  pl_sel, ph_sel, src_l, src_h, upd_l, upd_h, prod_w, sat_val;
	logic                 accept, out_fire, out_valid_q, ovf;

	assign accept   = in_valid && (ctl.seq == teq_pkg::SEQ_IN);
	assign out_free = !out_valid_q || out_ready;
	assign out_fire = (ctl.acc == teq_pkg::ACC_OUT) && out_free;

	assign pl_sel = pole_l_q[ctl.l_idx];
	assign ph_sel = pole_h_q[ctl.h_idx];
	assign src_l  = (ctl.seq == teq_pkg::SEQ_IN) ? sample_in : cur_l_q;
	assign src_h  = (ctl.seq == teq_pkg::SEQ_IN) ? sample_in : cur_h_q;
	assign prod_w = prod_q[W-1:0];
	assign upd_l  = pl_sel + prod_w;
	assign upd_h  = ph_sel + prod_w;

	always_comb begin
		case (ctl.mul_src)
			teq_pkg::MSRC_DL: mul_a = d_l_q;
			teq_pkg::MSRC_DH: mul_a = d_h_q;
			teq_pkg::MSRC_CL: mul_a = cur_l_q;
			default:          mul_a = '0;
		endcase
		case (ctl.mul_coef)
			teq_pkg::MCOEF_LOW:  mul_b = {{(BW-teq_pkg::COEF_W){1'b0}}, cfg.low_coef};
			teq_pkg::MCOEF_HIGH: mul_b = {{(BW-teq_pkg::COEF_W){1'b0}}, cfg.high_coef};
			teq_pkg::MGAIN_LOW:  mul_b = {1'b0, cfg.low_gain};
			teq_pkg::MGAIN_MID:  mul_b = {1'b0, cfg.mid_gain};
			teq_pkg::MGAIN_HIGH: mul_b = {1'b0, cfg.high_gain};
			default:             mul_b = '0;
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// Final sum saturates to the sample range
	assign prod_x  = {prod_q[PW-1], prod_q};
	assign sum     = acc_q + prod_x;
	assign ovf     = (sum[AW-1:W-1] != {(AW-W+1){sum[AW-1]}});
	assign sat_val = !ovf ? sum[W-1:0] :
		(sum[AW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < teq_pkg::NUM_POLES; i++) begin
				pole_l_q[i] <= '0;
				pole_h_q[i] <= '0;
			end
			for (int i = 0; i < teq_pkg::DLY_DEPTH; i++) begin
				dly_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.l_op == teq_pkg::CAS_UPD) begin
				pole_l_q[ctl.l_idx] <= upd_l;
			end
			if (ctl.h_op == teq_pkg::CAS_UPD) begin
				pole_h_q[ctl.h_idx] <= upd_h;
			end
			if (ctl.band) begin
				dly_q[2] <= dly_q[1];
				dly_q[1] <= dly_q[0];
				dly_q[0] <= x_q;
			end
			if (out_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= sample_in;
		end
		if (ctl.l_op == teq_pkg::CAS_UPD) begin
			cur_l_q <= upd_l;
		end
		if (ctl.h_op == teq_pkg::CAS_UPD) begin
			cur_h_q <= upd_h;
		end
		// band step: high = delayed - high lp, mid = high lp - low lp
		if (ctl.band) begin
			d_h_q <= dly_q[2] - cur_h_q;
			d_l_q <= cur_h_q - cur_l_q;
		end else begin
			if (ctl.l_op == teq_pkg::CAS_DIFF) begin
				d_l_q <= src_l - pl_sel;
			end
			if (ctl.h_op == teq_pkg::CAS_DIFF) begin
				d_h_q <= src_h - ph_sel;
			end
		end
		if (ctl.mul_src != teq_pkg::MSRC_NONE) begin
			prod_q <= mul_full >>> FRAC_BITS;
		end
		case (ctl.acc)
			teq_pkg::ACC_LOAD: acc_q <= prod_x;
			teq_pkg::ACC_ADD:  acc_q <= sum;
			default:           acc_q <= acc_q;
		endcase
		if (out_fire) begin
			out_q <= sat_val;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

endmodule
